// ===== hdl/lrsr_pkg.sv =====
// Shared types, sizes and codes for the LR shift-reduce parse engine.
// No dependencies; every other file takes its names from here, by scope or by import.
`default_nettype none

package lrsr_pkg;

  localparam int STATES      = 256;
  localparam int SYMBOLS     = 64;
  localparam int STACK_DEPTH = 32;
  localparam int MAX_REDUCES = 63;

  localparam int ST_W      = $clog2(STATES);
  localparam int SYM_W     = $clog2(SYMBOLS);
  localparam int TBL_DEPTH = STATES * SYMBOLS;
  localparam int TBL_AW    = ST_W + SYM_W;
  localparam int CLR_W     = $clog2(TBL_DEPTH + 1);
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int RED_W     = $clog2(MAX_REDUCES + 1);

  // input actions
  localparam logic [1:0] A_LOAD  = 2'd0;
  localparam logic [1:0] A_TOKEN = 2'd1;
  localparam logic [1:0] A_END   = 2'd2;

  // table entry kinds
  localparam logic [2:0] K_ERROR  = 3'd0;
  localparam logic [2:0] K_SHIFT  = 3'd1;
  localparam logic [2:0] K_GOTO   = 3'd2;
  localparam logic [2:0] K_REDUCE = 3'd3;
  localparam logic [2:0] K_ACCEPT = 3'd4;

  // result kinds
  localparam logic [2:0] R_REDUCED  = 3'd0;
  localparam logic [2:0] R_SHIFTED  = 3'd1;
  localparam logic [2:0] R_ACCEPTED = 3'd2;
  localparam logic [2:0] R_SYNTAX   = 3'd3;
  localparam logic [2:0] R_LIMIT    = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] table_state;
    logic [5:0] table_symbol;
    logic [2:0] entry_kind;
    logic [7:0] entry_next;
    logic [3:0] entry_pop;
    logic [5:0] entry_lhs;
    logic [7:0] entry_rule;
    logic [5:0] token_symbol;
    logic       token_unknown;
  } in_word_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] rule_id;
    logic [5:0] lhs_symbol;
    logic [5:0] stack_depth;
    logic [7:0] top_state;
    logic       last;
  } out_word_t;

  // packing order gives kind in the low bits
  typedef struct packed {
    logic [7:0] rule;
    logic [5:0] lhs;
    logic [3:0] pop;
    logic [7:0] next;
    logic [2:0] kind;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [3:0] pop_cnt;
    logic [7:0] push_val;
  } stk_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_GOTO,
    S_FAIL
  } seq_state_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [7:0] st,
                                                 input logic [5:0] sym);
    tbl_addr = {st[ST_W-1:0], sym[SYM_W-1:0]};
  endfunction

  function automatic logic in_table(input logic [7:0] st, input logic [5:0] sym);
    in_table = (int'(st) < STATES) && (int'(sym) < SYMBOLS);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lrsr_table.sv =====
// Action table memory with one write port, one registered read port and a
// clearing pass after reset that sets every entry to error. Uses lrsr_pkg.
`default_nettype none

module lrsr_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [lrsr_pkg::TBL_AW-1:0] wr_addr,
  input  wire lrsr_pkg::entry_t            wr_data,
  input  wire logic                        rd_en,
  input  wire logic [lrsr_pkg::TBL_AW-1:0] rd_addr,
  output lrsr_pkg::entry_t                 rd_data,
  output logic                             clr_done
);

  lrsr_pkg::entry_t                 mem [lrsr_pkg::TBL_DEPTH];
  lrsr_pkg::entry_t                 rd_data_r;
  logic [lrsr_pkg::CLR_W-1:0]       clr_cnt_r;
  logic [lrsr_pkg::CLR_W-1:0]       clr_cnt_nxt;

  assign clr_done    = (clr_cnt_r == lrsr_pkg::CLR_W'(lrsr_pkg::TBL_DEPTH));
  assign clr_cnt_nxt = clr_done ? clr_cnt_r : clr_cnt_r + 1'b1;
  assign rd_data     = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // sweep one entry a cycle until the pass is done
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt_r[lrsr_pkg::TBL_AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrsr_stack.sv =====
// State stack of the parser: register file, stack pointer, top and peek taps.
// Uses lrsr_pkg for sizes and the command struct.
`default_nettype none

module lrsr_stack (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lrsr_pkg::stk_cmd_t        cmd,
  output logic [lrsr_pkg::SP_W-1:0]      sp,
  output logic [7:0]                     top,
  output logic [7:0]                     peek
);

  logic [7:0]                  stack_r [lrsr_pkg::STACK_DEPTH];
  logic [lrsr_pkg::SP_W-1:0]   sp_r;
  logic [lrsr_pkg::SP_W-1:0]   top_idx;
  logic [lrsr_pkg::SP_W-1:0]   peek_idx;

  assign top_idx  = sp_r - 1'b1;
  // state left on top once pop_cnt states are dropped
  assign peek_idx = sp_r - lrsr_pkg::SP_W'(cmd.pop_cnt) - 1'b1;
  assign top      = stack_r[top_idx[lrsr_pkg::STK_AW-1:0]];
  assign peek     = stack_r[peek_idx[lrsr_pkg::STK_AW-1:0]];
  assign sp       = sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r       <= lrsr_pkg::SP_W'(1);
      stack_r[0] <= '0;
    end else if (cmd.clear) begin
      sp_r       <= lrsr_pkg::SP_W'(1);
      stack_r[0] <= '0;
    end else if (cmd.push) begin
      sp_r                                   <= sp_r + 1'b1;
      stack_r[sp_r[lrsr_pkg::STK_AW-1:0]]    <= cmd.push_val;
    end else if (cmd.pop) begin
      sp_r <= sp_r - lrsr_pkg::SP_W'(cmd.pop_cnt);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lr_shift_reduce_parse_engine.sv =====
// Top level of the LR parse engine: step sequencer, output register, config.
// Uses lrsr_pkg, lrsr_table and lrsr_stack.
//
//   channel  direction  handshake                 word
//   in_      input      in_valid / in_ready       lrsr_pkg::in_word_t
//   out_     output     out_valid / out_ready     lrsr_pkg::out_word_t
//   cfg_     input      cfg_wr_en (no wait)       end_symbol, 6 bits
//
// A load is written straight from idle. A token or end word is accepted, then
// the sequencer runs one table lookup per shift or accept and a lookup plus a
// goto fetch per reduce, and a separate step for an error or limit result;
// every lookup goes through the single registered read port of the table. A
// full output register stalls the step that emits. After reset the table
// clearing pass keeps in_ready low; configuration writes are taken throughout.
`default_nettype none

module lr_shift_reduce_parse_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lrsr_pkg::in_word_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lrsr_pkg::out_word_t        out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [5:0]            cfg_wr_data
);

  lrsr_pkg::seq_state_t         state_r, state_nxt;
  logic [5:0]                   end_symbol_r;
  logic [5:0]                   sym_r, sym_nxt;
  logic                         at_end_r, at_end_nxt;
  logic [lrsr_pkg::RED_W-1:0]   red_r, red_nxt;
  logic [2:0]                   fail_kind_r, fail_kind_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_valid_r;
  lrsr_pkg::out_word_t          out_data_r;

  logic                         tbl_wr_en;
  lrsr_pkg::entry_t             tbl_wr_data;
  logic                         tbl_rd_en;
  logic [lrsr_pkg::TBL_AW-1:0]  tbl_rd_addr;
  lrsr_pkg::entry_t             tbl_rd_data;
  logic                         clr_done;

  lrsr_pkg::stk_cmd_t           stk_cmd;
  logic [lrsr_pkg::SP_W-1:0]    stk_sp;
  logic [7:0]                   stk_top;
  logic [7:0]                   stk_peek;

  logic                         in_fire;
  logic                         out_free;
  logic                         emit;
  lrsr_pkg::out_word_t          emit_word;
  logic [2:0]                   ent_kind;
  logic                         stk_full;

  lrsr_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr_en),
    .wr_addr  (lrsr_pkg::tbl_addr(in_data.table_state, in_data.table_symbol)),
    .wr_data  (tbl_wr_data),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_data  (tbl_rd_data),
    .clr_done (clr_done)
  );

  lrsr_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .sp    (stk_sp),
    .top   (stk_top),
    .peek  (stk_peek)
  );

  assign in_ready  = (state_r == lrsr_pkg::S_IDLE) && clr_done;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ent_kind  = rd_ok_r ? tbl_rd_data.kind : lrsr_pkg::K_ERROR;
  assign stk_full  = (stk_sp >= lrsr_pkg::SP_W'(lrsr_pkg::STACK_DEPTH));

  assign tbl_wr_data = '{rule: in_data.entry_rule, lhs: in_data.entry_lhs,
                         pop: in_data.entry_pop, next: in_data.entry_next,
                         kind: in_data.entry_kind};

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    at_end_nxt    = at_end_r;
    red_nxt       = red_r;
    fail_kind_nxt = fail_kind_r;
    rd_ok_nxt     = rd_ok_r;
    tbl_wr_en     = 1'b0;
    tbl_rd_en     = 1'b0;
    tbl_rd_addr   = lrsr_pkg::tbl_addr(stk_top, sym_r);
    stk_cmd       = '0;
    emit          = 1'b0;
    emit_word     = '0;
    emit_word.stack_depth = 6'd1;

    unique case (state_r)
      lrsr_pkg::S_CLEAR: begin
        if (clr_done) begin
          state_nxt = lrsr_pkg::S_IDLE;
        end
      end

      lrsr_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.action) inside
            lrsr_pkg::A_LOAD: begin
              tbl_wr_en = lrsr_pkg::in_table(in_data.table_state,
                                             in_data.table_symbol);
            end
            lrsr_pkg::A_TOKEN, lrsr_pkg::A_END: begin
              at_end_nxt = (in_data.action == lrsr_pkg::A_END);
              sym_nxt    = at_end_nxt ? end_symbol_r : in_data.token_symbol;
              red_nxt    = '0;
              if (!at_end_nxt && in_data.token_unknown) begin
                fail_kind_nxt = lrsr_pkg::R_SYNTAX;
                state_nxt     = lrsr_pkg::S_FAIL;
              end else begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = lrsr_pkg::tbl_addr(stk_top, sym_nxt);
                rd_ok_nxt   = lrsr_pkg::in_table(stk_top, sym_nxt);
                state_nxt   = lrsr_pkg::S_LOOK;
              end
            end
            default: begin
              // unused action: drop
            end
          endcase
        end
      end

      lrsr_pkg::S_LOOK: begin
        stk_cmd.pop_cnt = tbl_rd_data.pop;
        if (ent_kind == lrsr_pkg::K_SHIFT && !at_end_r) begin
          if (stk_full) begin
            fail_kind_nxt = lrsr_pkg::R_LIMIT;
            state_nxt     = lrsr_pkg::S_FAIL;
          end else if (out_free) begin
            stk_cmd.push          = 1'b1;
            stk_cmd.push_val      = tbl_rd_data.next;
            emit                  = 1'b1;
            emit_word.result_kind = lrsr_pkg::R_SHIFTED;
            emit_word.stack_depth = 6'(stk_sp + 1'b1);
            emit_word.top_state   = tbl_rd_data.next;
            emit_word.last        = 1'b1;
            state_nxt             = lrsr_pkg::S_IDLE;
          end
        end else if (ent_kind == lrsr_pkg::K_REDUCE) begin
          if (red_r >= lrsr_pkg::RED_W'(lrsr_pkg::MAX_REDUCES) ||
              lrsr_pkg::SP_W'(tbl_rd_data.pop) >= stk_sp) begin
            fail_kind_nxt = lrsr_pkg::R_LIMIT;
            state_nxt     = lrsr_pkg::S_FAIL;
          end else if (out_free) begin
            stk_cmd.pop           = 1'b1;
            red_nxt               = red_r + 1'b1;
            emit                  = 1'b1;
            emit_word.result_kind = lrsr_pkg::R_REDUCED;
            emit_word.rule_id     = tbl_rd_data.rule;
            emit_word.lhs_symbol  = tbl_rd_data.lhs;
            emit_word.stack_depth = 6'(stk_sp - lrsr_pkg::SP_W'(tbl_rd_data.pop));
            emit_word.top_state   = stk_peek;
            // fetch the goto for the lhs from the state left on top
            tbl_rd_en             = 1'b1;
            tbl_rd_addr           = lrsr_pkg::tbl_addr(stk_peek, tbl_rd_data.lhs);
            rd_ok_nxt             = lrsr_pkg::in_table(stk_peek, tbl_rd_data.lhs);
            state_nxt             = lrsr_pkg::S_GOTO;
          end
        end else if (ent_kind == lrsr_pkg::K_ACCEPT) begin
          if (out_free) begin
            stk_cmd.clear         = 1'b1;
            emit                  = 1'b1;
            emit_word.result_kind = lrsr_pkg::R_ACCEPTED;
            emit_word.last        = 1'b1;
            state_nxt             = lrsr_pkg::S_IDLE;
          end
        end else begin
          fail_kind_nxt = lrsr_pkg::R_SYNTAX;
          state_nxt     = lrsr_pkg::S_FAIL;
        end
      end

      lrsr_pkg::S_GOTO: begin
        if (ent_kind != lrsr_pkg::K_GOTO) begin
          fail_kind_nxt = lrsr_pkg::R_SYNTAX;
          state_nxt     = lrsr_pkg::S_FAIL;
        end else if (stk_full) begin
          fail_kind_nxt = lrsr_pkg::R_LIMIT;
          state_nxt     = lrsr_pkg::S_FAIL;
        end else begin
          // push the goto state and look up the pending symbol from it
          stk_cmd.push     = 1'b1;
          stk_cmd.push_val = tbl_rd_data.next;
          tbl_rd_en        = 1'b1;
          tbl_rd_addr      = lrsr_pkg::tbl_addr(tbl_rd_data.next, sym_r);
          rd_ok_nxt        = lrsr_pkg::in_table(tbl_rd_data.next, sym_r);
          state_nxt        = lrsr_pkg::S_LOOK;
        end
      end

      lrsr_pkg::S_FAIL: begin
        if (out_free) begin
          stk_cmd.clear         = 1'b1;
          emit                  = 1'b1;
          emit_word.result_kind = fail_kind_r;
          emit_word.last        = 1'b1;
          state_nxt             = lrsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lrsr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrsr_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_symbol_r <= 6'd63;
    end else if (cfg_wr_en) begin
      end_symbol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    at_end_r    <= at_end_nxt;
    red_r       <= red_nxt;
    fail_kind_r <= fail_kind_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

  // hold a word until taken, refill in the same cycle it leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_word;
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    stk_sp >= lrsr_pkg::SP_W'(1) &&
    stk_sp <= lrsr_pkg::SP_W'(lrsr_pkg::STACK_DEPTH))
    else $error("stack pointer out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result emitted over a pending word");

  a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == lrsr_pkg::R_REDUCED |->
    !out_data_r.last)
    else $error("reduce result marked last");

  a_final_reset_stack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.result_kind == lrsr_pkg::R_ACCEPTED ||
                    out_data_r.result_kind == lrsr_pkg::R_SYNTAX ||
                    out_data_r.result_kind == lrsr_pkg::R_LIMIT) |->
    out_data_r.stack_depth == 6'd1 && out_data_r.top_state == 8'd0)
    else $error("final result without a cleared stack");

  a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> clr_done && !stk_cmd.push && !stk_cmd.pop)
    else $error("input taken while the sequencer is busy");

endmodule

`default_nettype wire

// ===== bench/lrsr_checker.sv =====
// Parse checker for the LR shift-reduce engine: tracks the action table, state
// stack and end column, predicts every result word and compares it on arrival.
// Depends on lrsr_pkg for word layouts, sizes and codes.
`timescale 1ns / 1ps

module lrsr_checker
  import lrsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_word_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  output int         errors,
  output int         pending
);

  entry_t     parse_rows [TBL_DEPTH];
  logic [7:0] parse_stack [STACK_DEPTH];
  int         stack_used;
  logic [5:0] end_col;
  out_word_t  parse_results [$];
  out_word_t  want;

  task automatic report(input string what);
    errors++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp_v);
    if (got !== exp_v)
      report($sformatf("%s got %0h expected %0h", name, got, exp_v));
  endtask

  function automatic entry_t entry_at(input logic [7:0] st, input logic [5:0] sym);
    if (int'(st) >= STATES || int'(sym) >= SYMBOLS) return '0;
    return parse_rows[int'(st) * SYMBOLS + int'(sym)];
  endfunction

  task automatic emit(input logic [2:0] kind, input logic [7:0] rule,
                      input logic [5:0] lhs, input logic fin);
    out_word_t r;
    r.result_kind = kind;
    r.rule_id     = rule;
    r.lhs_symbol  = lhs;
    r.stack_depth = 6'(stack_used);
    r.top_state   = parse_stack[stack_used - 1];
    r.last        = fin;
    parse_results = {parse_results, r};
  endtask

  // drop back to the lone state 0, then report
  task automatic unwind(input logic [2:0] kind);
    parse_stack[0] = 8'd0;
    stack_used = 1;
    emit(kind, 8'd0, 6'd0, 1'b1);
  endtask

  task automatic parse_word(input in_word_t w);
    entry_t     e;
    entry_t     g;
    logic [5:0] col;
    int         reduces;
    bit         busy;
    reduces = 0;
    busy = 1'b1;
    if (w.action == A_LOAD) begin
      if (int'(w.table_state) < STATES && int'(w.table_symbol) < SYMBOLS)
        parse_rows[int'(w.table_state) * SYMBOLS + int'(w.table_symbol)] =
          '{rule: w.entry_rule, lhs: w.entry_lhs, pop: w.entry_pop,
            next: w.entry_next, kind: w.entry_kind};
    end else if (w.action == A_TOKEN || w.action == A_END) begin
      if (w.action == A_TOKEN && w.token_unknown) begin
        unwind(R_SYNTAX);
        busy = 1'b0;
      end
      col = (w.action == A_END) ? end_col : w.token_symbol;
      while (busy) begin
        e = entry_at(parse_stack[stack_used - 1], col);
        busy = 1'b0;
        if (e.kind == K_SHIFT && w.action == A_TOKEN) begin
          if (stack_used >= STACK_DEPTH) begin
            unwind(R_LIMIT);
          end else begin
            parse_stack[stack_used] = e.next;
            stack_used++;
            emit(R_SHIFTED, 8'd0, 6'd0, 1'b1);
          end
        end else if (e.kind == K_REDUCE) begin
          if (reduces >= MAX_REDUCES || int'(e.pop) >= stack_used) begin
            unwind(R_LIMIT);
          end else begin
            reduces++;
            stack_used -= int'(e.pop);
            emit(R_REDUCED, e.rule, e.lhs, 1'b0);
            g = entry_at(parse_stack[stack_used - 1], e.lhs);
            if (g.kind != K_GOTO) begin
              unwind(R_SYNTAX);
            end else if (stack_used >= STACK_DEPTH) begin
              unwind(R_LIMIT);
            end else begin
              parse_stack[stack_used] = g.next;
              stack_used++;
              busy = 1'b1;
            end
          end
        end else if (e.kind == K_ACCEPT) begin
          unwind(R_ACCEPTED);
        end else begin
          unwind(R_SYNTAX);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (parse_rows[k]) parse_rows[k] = '0;
      parse_stack[0] = 8'd0;
      stack_used = 1;
      end_col = 6'd63;
      parse_results.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) end_col = cfg_wr_data;
      if (in_valid && in_ready) parse_word(in_data);
      if (out_valid && out_ready) begin
        if (parse_results.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = parse_results.pop_front();
          check_field("result_kind", 8'(out_data.result_kind), 8'(want.result_kind));
          check_field("rule_id", out_data.rule_id, want.rule_id);
          check_field("lhs_symbol", 8'(out_data.lhs_symbol), 8'(want.lhs_symbol));
          check_field("stack_depth", 8'(out_data.stack_depth), 8'(want.stack_depth));
          check_field("top_state", out_data.top_state, want.top_state);
          check_field("last", 8'(out_data.last), 8'(want.last));
        end
      end
    end
    pending = parse_results.size();
  end

endmodule

// ===== bench/tb_lr_shift_reduce_parse_engine.sv =====
// Testbench top for lr_shift_reduce_parse_engine: clock, reset, table loads,
// token streams with random pacing, receiver stalls, watchdog and verdict.
// Depends on lrsr_pkg, the engine RTL and lrsr_checker.
`timescale 1ns / 1ps

module tb_lr_shift_reduce_parse_engine;
  import lrsr_pkg::*;

  localparam int         ITEMS       = 350;
  localparam int         IDLE_LIMIT  = 60000;
  localparam int         HOLD_CYCLES = 500;
  localparam int         IN_W        = $bits(in_word_t);
  localparam logic [1:0] A_NONE      = 2'd3;
  localparam logic [2:0] K_UNKNOWN   = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;

  int errors;
  int pending;
  int sent;
  int burst_left;
  int quiet;
  bit hold_req;

  lr_shift_reduce_parse_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lrsr_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t load_word(input logic [7:0] st, input logic [5:0] sym,
                                         input logic [2:0] kind, input logic [7:0] next,
                                         input logic [3:0] pop, input logic [5:0] lhs,
                                         input logic [7:0] rule);
    in_word_t w;
    w = '0;
    w.action       = A_LOAD;
    w.table_state  = st;
    w.table_symbol = sym;
    w.entry_kind   = kind;
    w.entry_next   = next;
    w.entry_pop    = pop;
    w.entry_lhs    = lhs;
    w.entry_rule   = rule;
    return w;
  endfunction

  function automatic in_word_t token_word(input logic [1:0] act, input logic [5:0] sym,
                                          input logic unknown);
    in_word_t w;
    w = '0;
    w.action        = act;
    w.token_symbol  = sym;
    w.token_unknown = unknown;
    return w;
  endfunction

  // hold the word until the edge that takes it
  task automatic send(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.action != A_NONE) sent++;
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait for every result, then let loads settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_end_col(input logic [5:0] col);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= col;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: stall modes that change over time, plus one long hold-off
  initial begin : receiver
    int mode_left;
    int stall_mode;
    bit hold_taken;
    mode_left = 0;
    stall_mode = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t     w;
    in_word_t     plan [$];
    logic [63:0]  noise;
    int           p;
    int           n;
    int           r;
    int           i;
    bit           shifty;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    sent = 0;
    burst_left = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unknown token, end column error, unused action
    plan = {plan, token_word(A_TOKEN, 6'd0, 1'b0)};
    plan = {plan, token_word(A_TOKEN, 6'd63, 1'b1)};
    plan = {plan, token_word(A_END, 6'd0, 1'b0)};
    plan = {plan, token_word(A_NONE, 6'd0, 1'b0)};
    // reduce that loops on itself until the reduce limit
    plan = {plan, load_word(8'd0, 6'd1, K_SHIFT, 8'd1, 4'd0, 6'd0, 8'd0)};
    plan = {plan, load_word(8'd1, 6'd3, K_REDUCE, 8'd0, 4'd1, 6'd4, 8'd255)};
    plan = {plan, load_word(8'd0, 6'd4, K_GOTO, 8'd1, 4'd0, 6'd0, 8'd0)};
    plan = {plan, token_word(A_TOKEN, 6'd1, 1'b0)};
    plan = {plan, token_word(A_TOKEN, 6'd3, 1'b0)};
    // accept at end of input, directly and after a reduce
    plan = {plan, load_word(8'd0, 6'd63, K_ACCEPT, 8'd0, 4'd0, 6'd0, 8'd0)};
    plan = {plan, token_word(A_END, 6'd0, 1'b0)};
    plan = {plan, token_word(A_TOKEN, 6'd1, 1'b0)};
    plan = {plan, load_word(8'd1, 6'd63, K_REDUCE, 8'd0, 4'd1, 6'd5, 8'd9)};
    plan = {plan, load_word(8'd0, 6'd5, K_GOTO, 8'd2, 4'd0, 6'd0, 8'd0)};
    plan = {plan, load_word(8'd2, 6'd63, K_ACCEPT, 8'd0, 4'd0, 6'd0, 8'd0)};
    plan = {plan, token_word(A_END, 6'd0, 1'b0)};
    // goto found in a token column
    plan = {plan, token_word(A_TOKEN, 6'd4, 1'b0)};
    // reduce whose lhs column holds no goto
    plan = {plan, load_word(8'd0, 6'd6, K_REDUCE, 8'd0, 4'd0, 6'd7, 8'd3)};
    plan = {plan, token_word(A_TOKEN, 6'd6, 1'b0)};
    // pop as deep as the stack
    plan = {plan, load_word(8'd0, 6'd8, K_REDUCE, 8'd0, 4'd1, 6'd2, 8'd1)};
    plan = {plan, token_word(A_TOKEN, 6'd8, 1'b0)};
    // undefined kind with every field at its top
    plan = {plan, load_word(8'd0, 6'd9, K_UNKNOWN, 8'd255, 4'd15, 6'd63, 8'd255)};
    plan = {plan, token_word(A_TOKEN, 6'd9, 1'b0)};
    // zero-pop reduce plus goto grows the stack until a push overflows
    plan = {plan, load_word(8'd0, 6'd10, K_REDUCE, 8'd0, 4'd0, 6'd11, 8'd0)};
    plan = {plan, load_word(8'd0, 6'd11, K_GOTO, 8'd0, 4'd0, 6'd0, 8'd0)};
    plan = {plan, token_word(A_TOKEN, 6'd10, 1'b0)};
    // accept met in a token column
    plan = {plan, load_word(8'd0, 6'd12, K_ACCEPT, 8'd0, 4'd0, 6'd0, 8'd0)};
    plan = {plan, token_word(A_TOKEN, 6'd12, 1'b0)};
    foreach (plan[k]) begin
      send(plan[k]);
      pace();
    end

    // shift met in the end column
    drain(8);
    write_end_col(6'd1);
    send(token_word(A_END, 6'd0, 1'b0));
    pace();

    p = 0;
    while (sent < ITEMS) begin
      drain(8);
      case (p)
        0: write_end_col(6'd0);
        1: write_end_col(6'd63);
        default: write_end_col(($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
                                                           : 6'($urandom));
      endcase
      shifty = (p == 3) || ($urandom_range(0, 5) == 0);
      if (p == 2) hold_req = 1'b1;

      // table: a small grammar corner, now and then anywhere
      n = shifty ? 16 : $urandom_range(4, 14);
      for (i = 0; i < n; i++) begin
        noise = {$urandom, $urandom};
        w = noise[IN_W-1:0];
        w.action = A_LOAD;
        if (shifty) begin
          w.table_state  = 8'(i / 4);
          w.table_symbol = 6'(i % 4);
          w.entry_kind   = K_SHIFT;
          w.entry_next   = 8'($urandom_range(0, 3));
        end else if ($urandom_range(0, 9) != 0) begin
          r = $urandom_range(0, 19);
          w.table_state  = 8'($urandom_range(0, 3));
          w.table_symbol = 6'($urandom_range(0, 7));
          w.entry_next   = 8'($urandom_range(0, 3));
          w.entry_lhs    = 6'($urandom_range(0, 7));
          if ($urandom_range(0, 3) != 0) w.entry_pop = 4'($urandom_range(0, 2));
          w.entry_kind = (r < 6)  ? K_SHIFT  :
                         (r < 11) ? K_REDUCE :
                         (r < 15) ? K_GOTO   :
                         (r < 17) ? K_ACCEPT :
                         (r < 19) ? K_ERROR  : 3'($urandom_range(5, 7));
        end
        send(w);
        pace();
      end

      // tokens: a shift-only stream runs the stack into overflow
      n = shifty ? $urandom_range(35, 45) : $urandom_range(8, 30);
      for (i = 0; i < n; i++) begin
        noise = {$urandom, $urandom};
        w = noise[IN_W-1:0];
        if (shifty) begin
          w.action        = A_TOKEN;
          w.token_unknown = 1'b0;
          w.token_symbol  = 6'($urandom_range(0, 3));
        end else begin
          r = $urandom_range(0, 99);
          w.action = (r < 10) ? A_END : (r < 13) ? A_NONE : A_TOKEN;
          w.token_unknown = ($urandom_range(0, 19) == 0);
          if ($urandom_range(0, 6) != 0) w.token_symbol = 6'($urandom_range(0, 7));
        end
        send(w);
        pace();
      end
      p++;
    end

    drain(40);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
